/* src/priority_ready_queue_macros.svh */
// Assertion macros for the priority ready queue.
`ifndef PRIORITY_READY_QUEUE_MACROS_SVH
`define PRIORITY_READY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

`define PRQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("prq assertion failed");

`define PRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prq assertion failed");

`else

`define PRQ_ASSERT(label, clk, rst_n, prop)

`define PRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* src/prq_pkg.sv */
// Shared types and constants of the priority ready queue.
`default_nettype none

package prq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_W        = 16;
    localparam int PRIO_W      = 8;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_POP    = 2'd1,
        REQ_LOOKUP = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic              valid;
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   id;
    } t_entry;

    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctrl;

    typedef struct packed {
        logic take;
        logic match;
    } t_cell_stat;

endpackage

`default_nettype wire

/* src/priority_ready_queue.sv */
// Top level of the priority ready queue: chain of sorted slots and result register.
//
//  channel  | dir | tdata                                  | tuser
//  s_axis   | in  | thread_id[15:0] priority_req[23:16]    | req_type[1:0]
//  m_axis   | out | found[0] out_thread_id[16:1] out_prio  | status[1:0]
//           |     | [24:17], zero to bit 31                |
//
// The slot chain is updated at the clock edge on which a request is accepted.
// One result per request, held in a single output register; a new request is taken
// in the cycle the pending result leaves, so sustained rate is one per cycle while m_axis is ready.
// A stall on m_axis holds the result and drops s_axis tready.
// Synchronous reset empties the queue; slot contents are not cleared.
`default_nettype none
`include "priority_ready_queue_macros.svh"

module priority_ready_queue (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [23:0] i_s_axis_tdata,   // thread_id[15:0], priority_req[23:16]
    input  wire  [1:0]  i_s_axis_tuser,   // req_type[1:0]
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // found[0], out_thread_id[16:1], out_priority[24:17]
    output logic [1:0]  o_m_axis_tuser    // status[1:0]
);

    localparam int D = prq_pkg::QUEUE_DEPTH;

    prq_pkg::t_entry     w_entry [D];
    prq_pkg::t_cell_stat w_stat  [D];
    prq_pkg::t_entry     w_new;
    prq_pkg::t_entry     w_empty_entry;
    prq_pkg::t_cell_ctrl w_ctrl;
    prq_pkg::t_req       w_req;
    logic [D-1:0]        w_valid_vec;
    logic [D-1:0]        w_match_vec;
    logic                w_accept;
    logic                w_full;
    logic                w_empty;

    logic                      r_out_valid;
    prq_pkg::t_status          r_status;
    logic                      r_found;
    logic [prq_pkg::ID_W-1:0]  r_id;
    logic [prq_pkg::PRIO_W-1:0] r_prio;
    prq_pkg::t_status          n_status;
    logic                      n_found;
    logic [prq_pkg::ID_W-1:0]  n_id;
    logic [prq_pkg::PRIO_W-1:0] n_prio;

    assign w_req          = prq_pkg::t_req'(i_s_axis_tuser);
    assign w_new.valid    = 1'b1;
    assign w_new.id       = i_s_axis_tdata[15:0];
    assign w_new.prio     = i_s_axis_tdata[23:16];
    assign w_empty_entry  = '0;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_full          = w_valid_vec[D-1];
    assign w_empty         = !w_valid_vec[0];

    assign w_ctrl.ins = w_accept && (w_req == prq_pkg::REQ_INSERT) && !w_full;
    assign w_ctrl.pop = w_accept && (w_req == prq_pkg::REQ_POP) && !w_empty;

    genvar g;
    generate
        for (g = 0; g < D; g++) begin : g_cell
            prq_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctrl      (w_ctrl),
                .i_new       (w_new),
                .i_left      ((g == 0) ? w_new : w_entry[(g == 0) ? 0 : g-1]),
                .i_left_take ((g == 0) ? 1'b0 : w_stat[(g == 0) ? 0 : g-1].take),
                .i_right     ((g == D-1) ? w_empty_entry : w_entry[(g == D-1) ? g : g+1]),
                .o_entry     (w_entry[g]),
                .o_stat      (w_stat[g])
            );
            assign w_valid_vec[g] = w_entry[g].valid;
            assign w_match_vec[g] = w_stat[g].match;
        end
    endgenerate

    always_comb begin
        n_status = prq_pkg::ST_OK;
        n_found  = 1'b0;
        n_id     = '0;
        n_prio   = '0;
        unique case (w_req)
            prq_pkg::REQ_INSERT: begin
                if (w_full) begin
                    n_status = prq_pkg::ST_FULL;
                end
            end
            prq_pkg::REQ_POP: begin
                if (w_empty) begin
                    n_status = prq_pkg::ST_EMPTY;
                end else begin
                    n_id   = w_entry[0].id;
                    n_prio = w_entry[0].prio;
                end
            end
            prq_pkg::REQ_LOOKUP: begin
                n_found = |w_match_vec;
            end
            default: begin
                n_status = prq_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_accept) begin
            r_status <= n_status;
            r_found  <= n_found;
            r_id     <= n_id;
            r_prio   <= n_prio;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_status;
    assign o_m_axis_tdata  = {7'd0, r_prio, r_id, r_found};

    // occupied slots always form a run from the head
    `PRQ_ASSERT(a_thermo, i_clk, i_rst_n, ((w_valid_vec + D'(1)) & w_valid_vec) == '0)
    `PRQ_ASSERT_NEXT(a_ins_count, i_clk, i_rst_n, w_ctrl.ins,
        $countones(w_valid_vec) == $past($countones(w_valid_vec)) + 1)
    `PRQ_ASSERT_NEXT(a_pop_count, i_clk, i_rst_n, w_ctrl.pop,
        $countones(w_valid_vec) + 1 == $past($countones(w_valid_vec)))
    `PRQ_ASSERT_NEXT(a_pop_head, i_clk, i_rst_n, w_ctrl.pop,
        r_status == prq_pkg::ST_OK && r_prio == $past(w_entry[0].prio))
    `PRQ_ASSERT_NEXT(a_full_hold, i_clk, i_rst_n,
        w_accept && w_req == prq_pkg::REQ_INSERT && w_full,
        r_status == prq_pkg::ST_FULL && $stable(w_valid_vec))

endmodule

`default_nettype wire

/* src/prq_cell.sv */
// One slot of the sorted shift chain: holds an entry and moves it left or right.
`default_nettype none

module prq_cell (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire prq_pkg::t_cell_ctrl i_ctrl,
    input  wire prq_pkg::t_entry     i_new,
    input  wire prq_pkg::t_entry     i_left,
    input  wire                      i_left_take,
    input  wire prq_pkg::t_entry     i_right,
    output prq_pkg::t_entry          o_entry,
    output prq_pkg::t_cell_stat      o_stat
);

    prq_pkg::t_entry r_entry;
    prq_pkg::t_entry n_entry;
    logic            w_take;

    // new entry belongs here or before: slot empty or strictly greater
    assign w_take = !r_entry.valid || (r_entry.prio > i_new.prio);

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.pop) begin
            n_entry = i_right;
        end else if (i_ctrl.ins) begin
            if (i_left_take) begin
                n_entry = i_left;
            end else if (w_take) begin
                n_entry = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.prio <= n_entry.prio;
        r_entry.id   <= n_entry.id;
    end

    assign o_entry      = r_entry;
    assign o_stat.take  = w_take;
    assign o_stat.match = r_entry.valid && (r_entry.id == i_new.id);

endmodule

`default_nettype wire
